// ===== design/kbd_pkg.sv =====
`default_nettype none
package kbd_pkg;

   // Number of key slots held internally, and number shown in the report
   localparam int KEY_SLOTS   = 6;
   localparam int SHOWN_SLOTS = 6;

   // Modifier usage range: MOD_FIRST up to, not including, MOD_END
   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam logic [7:0] MOD_END   = 8'hE8;

   // Width of a slot position count, able to hold KEY_SLOTS itself
   localparam int SLOT_CNT_W = $clog2(KEY_SLOTS + 1);

   typedef logic [7:0] key_code_type;
   typedef logic [KEY_SLOTS-1:0][7:0] slot_array_type;
   typedef logic [SLOT_CNT_W-1:0] slot_cnt_type;

endpackage
`default_nettype wire

// ===== design/keyboard_report_key_list_unit.sv =====
// Keyboard report key list: modifier bitmap plus key slots, newest first.
// An accepted key event passes the input register, then the report registers,
// before it shows on the rsp_ ports.
// Throughput: one event per cycle; busy is always low, and the combinational
// slot compare, close-up and shift sets that rate. The receiver cannot stall.
// Reset (synchronous, active high) clears the bitmap, all slots and the strobes.
`default_nettype none
module keyboard_report_key_list_unit
   import kbd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [7:0]   req_key_code,
   input  wire logic         req_pressed,
   output logic              rsp_valid,
   output logic [7:0]        rsp_modifier_bits,
   output logic [7:0]        rsp_key_slot_1,
   output logic [7:0]        rsp_key_slot_2,
   output logic [7:0]        rsp_key_slot_3,
   output logic [7:0]        rsp_key_slot_4,
   output logic [7:0]        rsp_key_slot_5,
   output logic [7:0]        rsp_key_slot_6
);

   // input register
   logic           req_valid_ff;
   logic           req_valid_in;
   key_code_type   req_code_ff;
   logic           req_pressed_ff;

   // report state, which is also the result register
   logic [7:0]     mod_ff;
   logic [7:0]     mod_in;
   slot_array_type slots_ff;
   slot_array_type slots_in;
   logic           rsp_valid_ff;

   // decode of the registered event
   logic           is_mod;
   logic           is_key;
   logic [KEY_SLOTS-1:0] match;
   slot_cnt_type   keep_pos [KEY_SLOTS];
   slot_array_type packed_slots;
   logic [SHOWN_SLOTS-1:0][7:0] shown;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   // capture each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) begin
         req_code_ff    <= req_key_code;
         req_pressed_ff <= req_pressed;
      end
   end

   assign is_mod = (req_code_ff >= MOD_FIRST) && (req_code_ff < MOD_END);
   assign is_key = (req_code_ff != '0) && !is_mod;

   // new position of every slot once matching codes are removed
   always_comb begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
         match[k] = (slots_ff[k] == req_code_ff);
      end
      for (int k = 0; k < KEY_SLOTS; k++) begin
         keep_pos[k] = slot_cnt_type'(k);
         for (int m = 0; m < k; m++) begin
            keep_pos[k] = keep_pos[k] - slot_cnt_type'(match[m]);
         end
      end
   end

   // close up the gaps left by removed codes, zeros at the old end
   always_comb begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
         packed_slots[j] = '0;
         for (int k = j; k < KEY_SLOTS; k++) begin
            if (!match[k] && (keep_pos[k] == slot_cnt_type'(j))) begin
               packed_slots[j] = slots_ff[k];
            end
         end
      end
   end

   // next report state
   always_comb begin
      mod_in   = mod_ff;
      slots_in = slots_ff;
      if (req_valid_ff) begin
         if (is_mod) begin
            mod_in[req_code_ff[2:0]] = req_pressed_ff;
         end else if (is_key) begin
            if (req_pressed_ff) begin
               slots_in[0] = req_code_ff;
               for (int j = 1; j < KEY_SLOTS; j++) begin
                  slots_in[j] = packed_slots[j-1];
               end
            end else begin
               slots_in = packed_slots;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff       <= '0;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_ff       <= mod_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // report shows the newest SHOWN_SLOTS slots, zero past the slot count
   for (genvar j = 0; j < SHOWN_SLOTS; j++) begin : g_shown
      if (j < KEY_SLOTS) begin : g_slot
         assign shown[j] = slots_ff[j];
      end else begin : g_empty
         assign shown[j] = '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_modifier_bits = mod_ff;
   assign rsp_key_slot_1    = shown[0];
   assign rsp_key_slot_2    = shown[1];
   assign rsp_key_slot_3    = shown[2];
   assign rsp_key_slot_4    = shown[3];
   assign rsp_key_slot_5    = shown[4];
   assign rsp_key_slot_6    = shown[5];

   // every accepted transfer gives a result once through the input and report registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid_in |-> ##2 rsp_valid)
      else $error("result strobe missing after accepted event");

   // no result without an event in the input register
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_valid_ff))
      else $error("result strobe without an event");

   // a pressed key lands in the front slot
   a_front_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && is_key && req_pressed_ff) |=> (slots_ff[0] == $past(req_code_ff)))
      else $error("pressed key not in front slot");

   // a modifier press sets its bit
   a_mod_set: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && is_mod && req_pressed_ff) |=> mod_ff[$past(req_code_ff[2:0])])
      else $error("modifier bit not set on press");

   // report holds while no event is applied
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> ($stable(slots_ff) && $stable(mod_ff)))
      else $error("report changed without an event");

endmodule
`default_nettype wire
